[rtl/sine_position_embedding_macros.svh]
// ---------------------------------------------------------------------------
// sine position embedding assertion macros
// shared concurrent checks, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef SINE_POSITION_EMBEDDING_MACROS_SVH
`define SINE_POSITION_EMBEDDING_MACROS_SVH

// same-cycle implication
`define SPE_ASSERT_IMP(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication
`define SPE_ASSERT_NXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/spe_pkg.sv]
// ---------------------------------------------------------------------------
// spe_pkg
// shared widths, constants, types and elaboration-time functions
// ---------------------------------------------------------------------------
package spe_pkg;

    localparam int SIZE_W = 8;
    localparam int POS_W  = 8;
    localparam int FREQ_W = 31;
    localparam int TURN_W = 32;
    localparam int X_W    = 31;
    localparam int VAL_W  = 16;

    localparam logic [63:0] LOG2_1000_Q32 = 64'd42802717582;
    localparam logic [X_W-1:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [15:0] Q14_ONE       = 16'd16384;
    localparam int ROOT_BITS              = 24;

    // odd Taylor coefficients of sin(pi/2 x), Q30
    localparam logic [X_W-1:0] COEF_C9 = 31'd172272;
    localparam logic [X_W-1:0] HORNER_COEF [4] =
        '{31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713};

    // register addresses (word index)
    localparam logic REG_GRID_HEIGHT = 1'b0;
    localparam logic REG_GRID_WIDTH  = 1'b1;

    // side information that travels with a transaction
    typedef struct packed {
        logic odd;
        logic oor;
    } spe_tag_t;

    // truncated integer square root
    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // frequency factor 2^-e in Q30 from exponent e in Q32
    function automatic logic [FREQ_W-1:0] freq_from_exp(input logic [63:0] e);
        logic [63:0] m;
        logic [63:0] root;
        logic [31:0] fr;
        logic [31:0] ip;
        ip   = e[63:32];
        fr   = e[31:0];
        m    = 64'd1 << 30;
        root = isqrt64(64'd1 << 59);
        for (int i = 1; i <= ROOT_BITS; i++)
        begin
            if (fr[32-i])
                m = (m * root) >> 30;
            root = isqrt64(root << 30);
        end
        if (ip >= 32'd31)
            return '0;
        return FREQ_W'(m >> ip);
    endfunction

endpackage

[rtl/spe_div.sv]
// ---------------------------------------------------------------------------
// spe_div
// pipelined restoring divider, a few quotient bits per stage, 8-bit divisor
// ---------------------------------------------------------------------------
module spe_div
    import spe_pkg::*;
#(
    parameter int DW  = 41,
    parameter int BPS = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [DW-1:0]       in_num,
    input  logic [SIZE_W-1:0]   in_den,
    input  spe_tag_t            in_tag,
    output logic                out_valid,
    output logic [TURN_W-1:0]   out_quo,
    output spe_tag_t            out_tag
);

    localparam int NS  = (DW + BPS - 1) / BPS;
    localparam int PDW = NS * BPS;

    // stage boundaries: index 0 is the input, s+1 the output of stage s
    logic                st_valid [NS+1];
    logic [SIZE_W-1:0]   st_rem   [NS+1];
    logic [PDW-1:0]      st_num   [NS+1];
    logic [PDW-1:0]      st_quo   [NS+1];
    logic [SIZE_W-1:0]   st_den   [NS+1];
    spe_tag_t            st_tag   [NS+1];

    assign st_valid[0] = in_valid;
    assign st_rem[0]   = '0;
    assign st_num[0]   = PDW'(in_num);
    assign st_quo[0]   = '0;
    assign st_den[0]   = in_den;
    assign st_tag[0]   = in_tag;

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic                valid_reg;
        logic [SIZE_W-1:0]   rem_reg, rem_next;
        logic [PDW-1:0]      num_reg, num_next;
        logic [PDW-1:0]      quo_reg, quo_next;
        logic [SIZE_W-1:0]   den_reg;
        spe_tag_t            tag_reg;
        logic [SIZE_W:0]     trial;

        // BPS shift-subtract steps on the narrow remainder
        always_comb
        begin
            rem_next = st_rem[s];
            num_next = st_num[s];
            quo_next = st_quo[s];
            trial    = '0;
            for (int b = 0; b < BPS; b++)
            begin
                trial    = {rem_next, num_next[PDW-1]};
                num_next = num_next << 1;
                if (trial >= {1'b0, st_den[s]})
                begin
                    rem_next = SIZE_W'(trial - {1'b0, st_den[s]});
                    quo_next = {quo_next[PDW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[SIZE_W-1:0];
                    quo_next = {quo_next[PDW-2:0], 1'b0};
                end
            end
        end

        // valid bit
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else
                valid_reg <= st_valid[s];
        end

        // payload
        always_ff @(posedge clk)
        begin
            rem_reg <= rem_next;
            num_reg <= num_next;
            quo_reg <= quo_next;
            den_reg <= st_den[s];
            tag_reg <= st_tag[s];
        end

        assign st_valid[s+1] = valid_reg;
        assign st_rem[s+1]   = rem_reg;
        assign st_num[s+1]   = num_reg;
        assign st_quo[s+1]   = quo_reg;
        assign st_den[s+1]   = den_reg;
        assign st_tag[s+1]   = tag_reg;
    end

    assign out_valid = st_valid[NS];
    assign out_quo   = st_quo[NS][TURN_W-1:0];
    assign out_tag   = st_tag[NS];

endmodule

[rtl/spe_sine.sv]
// ---------------------------------------------------------------------------
// spe_sine
// pipelined quarter-wave sine polynomial, Q30 in, signed Q14 out
// ---------------------------------------------------------------------------
module spe_sine
    import spe_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic [1:0]              in_quad,
    input  logic [X_W-1:0]          in_x,
    input  logic                    in_oor,
    output logic                    out_valid,
    output logic signed [VAL_W-1:0] out_value
);

    // square stage
    logic               sq_valid_reg;
    logic [1:0]         sq_quad_reg;
    logic               sq_oor_reg;
    logic [X_W-1:0]     sq_x_reg;
    logic [X_W-1:0]     sq_x2_reg;
    logic [2*X_W-1:0]   sq_prod;

    assign sq_prod = {{X_W{1'b0}}, in_x} * {{X_W{1'b0}}, in_x};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sq_valid_reg <= 1'b0;
        else
            sq_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        sq_quad_reg <= in_quad;
        sq_oor_reg  <= in_oor;
        sq_x_reg    <= in_x;
        sq_x2_reg   <= sq_prod[X_W+29:30];
    end

    // horner chain, one multiply per stage
    logic               h_valid [5];
    logic [1:0]         h_quad  [5];
    logic               h_oor   [5];
    logic [X_W-1:0]     h_x     [5];
    logic [X_W-1:0]     h_x2    [5];
    logic [X_W-1:0]     h_t     [5];

    assign h_valid[0] = sq_valid_reg;
    assign h_quad[0]  = sq_quad_reg;
    assign h_oor[0]   = sq_oor_reg;
    assign h_x[0]     = sq_x_reg;
    assign h_x2[0]    = sq_x2_reg;
    assign h_t[0]     = COEF_C9;

    for (genvar i = 0; i < 4; i++)
    begin : g_horner
        logic               valid_reg;
        logic [1:0]         quad_reg;
        logic               oor_reg;
        logic [X_W-1:0]     x_reg;
        logic [X_W-1:0]     x2_reg;
        logic [X_W-1:0]     t_reg, t_next;
        logic [2*X_W-1:0]   prod;

        assign prod   = {{X_W{1'b0}}, h_x2[i]} * {{X_W{1'b0}}, h_t[i]};
        assign t_next = HORNER_COEF[i] - prod[X_W+29:30];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg <= 1'b0;
            else
                valid_reg <= h_valid[i];
        end

        always_ff @(posedge clk)
        begin
            quad_reg <= h_quad[i];
            oor_reg  <= h_oor[i];
            x_reg    <= h_x[i];
            x2_reg   <= h_x2[i];
            t_reg    <= t_next;
        end

        assign h_valid[i+1] = valid_reg;
        assign h_quad[i+1]  = quad_reg;
        assign h_oor[i+1]   = oor_reg;
        assign h_x[i+1]     = x_reg;
        assign h_x2[i+1]    = x2_reg;
        assign h_t[i+1]     = t_reg;
    end

    // final multiply by x
    logic               y_valid_reg;
    logic [1:0]         y_quad_reg;
    logic               y_oor_reg;
    logic [X_W-1:0]     y_reg;
    logic [2*X_W-1:0]   y_prod;

    assign y_prod = {{X_W{1'b0}}, h_x[4]} * {{X_W{1'b0}}, h_t[4]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            y_valid_reg <= 1'b0;
        else
            y_valid_reg <= h_valid[4];
    end

    always_ff @(posedge clk)
    begin
        y_quad_reg <= h_quad[4];
        y_oor_reg  <= h_oor[4];
        y_reg      <= y_prod[X_W+29:30];
    end

    // round to Q14, cap, apply sign
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;
    logic [X_W:0]            rnd_sum;
    logic [VAL_W-1:0]        mag;

    always_comb
    begin
        rnd_sum = {1'b0, y_reg} + (32'd1 << 15);
        mag     = rnd_sum[X_W:16];
        if (mag > Q14_ONE)
            mag = Q14_ONE;
        if (y_oor_reg)
            out_value_next = '0;
        else if (y_quad_reg[1])
            out_value_next = -$signed(mag);
        else
            out_value_next = $signed(mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= y_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
    end

    assign out_valid = out_valid_reg;
    assign out_value = out_value_reg;

endmodule

[rtl/sine_position_embedding.sv]
// ---------------------------------------------------------------------------
// sine_position_embedding
// 2D sinusoidal position embedding, one value per channel and grid cell
// ---------------------------------------------------------------------------
// throughput: one transaction per cycle, busy is never raised
// the pipelined divider (4 quotient bits per stage) dominates the latency
// reset: pipeline emptied, grid_height and grid_width return to 72
// results cannot be stalled by the receiver
`include "sine_position_embedding_macros.svh"

module sine_position_embedding
    import spe_pkg::*;
#(
    parameter int NUM_CHANNELS = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [7:0]              channel_index,
    input  logic [6:0]              row_index,
    input  logic [6:0]              column_index,
    output logic                    done,
    output logic signed [VAL_W-1:0] embed_value,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    localparam int HALF = NUM_CHANNELS / 2;
    localparam int JD   = (HALF + 1) / 2;
    localparam int JW   = (JD > 1) ? $clog2(JD) : 1;
    localparam int DW   = POS_W + FREQ_W + 2;

    // configuration registers
    logic [SIZE_W-1:0] grid_height_reg;
    logic [SIZE_W-1:0] grid_width_reg;

    assign pready = 1'b1;
    assign busy   = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_height_reg <= 8'd72;
            grid_width_reg  <= 8'd72;
        end
        else if (psel && penable && pwrite && pready)
        begin
            if (paddr[2] == REG_GRID_HEIGHT)
                grid_height_reg <= pwdata[7:0];
            else
                grid_width_reg <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_GRID_WIDTH) ? {24'd0, grid_width_reg}
                                                 : {24'd0, grid_height_reg};

    // frequency factor table, built at elaboration
    logic [FREQ_W-1:0] freq_tab [JD];

    for (genvar g = 0; g < JD; g++)
    begin : g_freq
        localparam logic [63:0] EXP_Q32 =
            (64'(2 * g) * LOG2_1000_Q32) / 64'(HALF);
        localparam logic [FREQ_W-1:0] FREQ = freq_from_exp(EXP_Q32);
        assign freq_tab[g] = FREQ;
    end

    // stage 1: channel decode and table lookup
    logic               s1_valid_reg;
    logic [POS_W-1:0]   s1_pos_reg;
    logic [SIZE_W-1:0]  s1_size_reg;
    logic [FREQ_W-1:0]  s1_freq_reg;
    spe_tag_t           s1_tag_reg;

    logic [31:0]        c32;
    logic [31:0]        k32;
    logic               use_row;
    logic [JW-1:0]      j_idx;
    logic [POS_W-1:0]   pos_c;
    logic [SIZE_W-1:0]  size_c;
    logic [FREQ_W-1:0]  freq_c;
    spe_tag_t           tag_c;

    always_comb
    begin
        c32     = 32'(channel_index);
        use_row = c32 < 32'(HALF);
        k32     = use_row ? c32 : c32 - 32'(HALF);
        j_idx   = JW'(k32 >> 1);
        freq_c  = ((k32 >> 1) < 32'(JD)) ? freq_tab[j_idx] : '0;
        pos_c   = use_row ? POS_W'(row_index) + 8'd1 : POS_W'(column_index) + 8'd1;
        size_c  = use_row ? grid_height_reg : grid_width_reg;
        if (size_c == '0)
            size_c = 8'd1;
        tag_c.odd = k32[0];
        tag_c.oor = c32 >= 32'(NUM_CHANNELS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_pos_reg  <= pos_c;
        s1_size_reg <= size_c;
        s1_freq_reg <= freq_c;
        s1_tag_reg  <= tag_c;
    end

    // stage 2: position times frequency, times four
    logic               s2_valid_reg;
    logic [DW-1:0]      s2_prod_reg;
    logic [SIZE_W-1:0]  s2_size_reg;
    spe_tag_t           s2_tag_reg;
    logic [DW-1:0]      prod_c;

    assign prod_c = (DW'(s1_pos_reg) * DW'(s1_freq_reg)) << 2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        s2_prod_reg <= prod_c;
        s2_size_reg <= s1_size_reg;
        s2_tag_reg  <= s1_tag_reg;
    end

    // divide by the grid size
    logic               dv_valid;
    logic [TURN_W-1:0]  dv_quo;
    spe_tag_t           dv_tag;

    spe_div #(
        .DW  (DW),
        .BPS (4)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid_reg),
        .in_num    (s2_prod_reg),
        .in_den    (s2_size_reg),
        .in_tag    (s2_tag_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_tag   (dv_tag)
    );

    // stage 3: phase, quadrant and folded argument
    logic               s3_valid_reg;
    logic [1:0]         s3_quad_reg;
    logic [X_W-1:0]     s3_x_reg;
    logic               s3_oor_reg;
    logic [TURN_W-1:0]  turns_c;
    logic [X_W-1:0]     x_c;

    always_comb
    begin
        turns_c = dv_quo + (dv_tag.odd ? 32'h4000_0000 : 32'd0);
        if (turns_c[30])
            x_c = ONE_Q30 - {1'b0, turns_c[29:0]};
        else
            x_c = {1'b0, turns_c[29:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        s3_quad_reg <= turns_c[31:30];
        s3_x_reg    <= x_c;
        s3_oor_reg  <= dv_tag.oor;
    end

    // sine polynomial and output register
    spe_sine u_sine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s3_valid_reg),
        .in_quad   (s3_quad_reg),
        .in_x      (s3_x_reg),
        .in_oor    (s3_oor_reg),
        .out_valid (done),
        .out_value (embed_value)
    );

    // checks
    `SPE_ASSERT_NXT(a_accept_enters, start && !busy, s1_valid_reg, "accepted transaction lost")
    `SPE_ASSERT_IMP(a_x_range, s3_valid_reg, s3_x_reg <= ONE_Q30, "folded argument above one")
    `SPE_ASSERT_IMP(a_out_range, done, embed_value >= -16'sd16384 && embed_value <= 16'sd16384, "result out of range")

endmodule
